### rtl/bdq_pkg.sv
// Shared constants, codes and control types of the bounded deque with search.
package bdq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ACT_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 7;
    localparam int LEN_W = 7;

    localparam int IN_W  = ((ACT_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W = ((ST_W + VAL_W + POS_W + LEN_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic ready;
        logic start;
        logic scan;
        logic load_out;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_req;
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

### rtl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bdq_ctrl.sv
// Controller state machine: accepts an item, steps a search scan, hands off the result.
module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bdq_pkg::t_stat i_stat,
    output bdq_pkg::t_cmd  o_cmd
);

    bdq_pkg::t_state r_state;
    bdq_pkg::t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.ready    = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.scan     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            bdq_pkg::S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_stat.scan_req ? bdq_pkg::S_SCAN : bdq_pkg::S_DONE;
                end
            end
            bdq_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = bdq_pkg::S_DONE;
                end
            end
            bdq_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/bdq_dp.sv
// Datapath: entry RAM, ring pointers, search scan and the output register.
module bdq_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bdq_pkg::t_cmd              i_cmd,
    input  logic [bdq_pkg::IN_W-1:0]   i_in_data,
    input  logic                       i_out_ready,
    output bdq_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    output logic [bdq_pkg::OUT_W-1:0]  o_out_data
);

    localparam int SUM_W = bdq_pkg::CNT_W + 1;

    function automatic logic [bdq_pkg::IDX_W-1:0] ring_pos(
        input logic [bdq_pkg::IDX_W-1:0] base,
        input logic [bdq_pkg::CNT_W-1:0] off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(bdq_pkg::DEPTH)) begin
            sum = sum - SUM_W'(bdq_pkg::DEPTH);
        end
        return sum[bdq_pkg::IDX_W-1:0];
    endfunction

    logic [bdq_pkg::ACT_W-1:0] in_act;
    logic [bdq_pkg::VAL_W-1:0] in_val;

    logic [bdq_pkg::IDX_W-1:0] r_front;
    logic [bdq_pkg::CNT_W-1:0] r_count;
    logic [bdq_pkg::ACT_W-1:0] r_act;
    logic [bdq_pkg::VAL_W-1:0] r_key;
    logic [bdq_pkg::ST_W-1:0]  r_status;
    logic [bdq_pkg::POS_W-1:0] r_pos;
    logic [bdq_pkg::CNT_W-1:0] r_idx;

    logic                      r_out_valid;
    logic [bdq_pkg::ST_W-1:0]  r_out_status;
    logic [bdq_pkg::VAL_W-1:0] r_out_removed;
    logic [bdq_pkg::POS_W-1:0] r_out_pos;
    logic [bdq_pkg::LEN_W-1:0] r_out_len;

    logic                      is_empty;
    logic                      is_full;
    logic [bdq_pkg::CNT_W-1:0] off;
    logic [bdq_pkg::IDX_W-1:0] addr;
    logic [bdq_pkg::IDX_W-1:0] front_inc;
    logic [bdq_pkg::CNT_W-1:0] idx_nxt;
    logic [31:0]               idx_wide;
    logic [31:0]               cnt_wide;
    logic                      wr_en;
    logic                      rd_en;
    logic [bdq_pkg::VAL_W-1:0] rdata;
    logic                      hit;
    logic                      scan_last;
    logic                      pop_ok;

    assign in_act = i_in_data[bdq_pkg::ACT_W-1:0];
    assign in_val = i_in_data[bdq_pkg::ACT_W +: bdq_pkg::VAL_W];

    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign idx_nxt   = r_idx + 1'b1;
    assign idx_wide  = 32'(idx_nxt);
    assign cnt_wide  = 32'(r_count);
    assign hit       = (rdata == r_key);
    assign scan_last = (idx_nxt == r_count);
    assign front_inc = (r_front == bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1)) ? '0 : r_front + 1'b1;

    assign o_stat.scan_req = (in_act == bdq_pkg::ACT_SEARCH) && !is_empty;
    assign o_stat.scan_end = hit || scan_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // One shared ring adder serves the push write, the pop read and the scan reads.
    always_comb begin
        off   = '0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        if (i_cmd.start) begin
            case (in_act)
                bdq_pkg::ACT_PUSH_FRONT: begin
                    off   = bdq_pkg::CNT_W'(bdq_pkg::DEPTH - 1);
                    wr_en = !is_full;
                end
                bdq_pkg::ACT_PUSH_BACK: begin
                    off   = r_count;
                    wr_en = !is_full;
                end
                bdq_pkg::ACT_POP_FRONT: begin
                    rd_en = !is_empty;
                end
                bdq_pkg::ACT_POP_BACK: begin
                    off   = r_count - 1'b1;
                    rd_en = !is_empty;
                end
                bdq_pkg::ACT_SEARCH: begin
                    rd_en = !is_empty;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.scan && !(hit || scan_last)) begin
            off   = idx_nxt;
            rd_en = 1'b1;
        end
    end

    assign addr = ring_pos(r_front, off);

    bdq_ram #(
        .WIDTH (bdq_pkg::VAL_W),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (addr),
        .i_wdata (in_val),
        .i_re    (rd_en),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            case (in_act)
                bdq_pkg::ACT_PUSH_FRONT: begin
                    if (!is_full) begin
                        r_front <= addr;
                        r_count <= r_count + 1'b1;
                    end
                end
                bdq_pkg::ACT_PUSH_BACK: begin
                    if (!is_full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                bdq_pkg::ACT_POP_FRONT: begin
                    if (!is_empty) begin
                        r_front <= front_inc;
                        r_count <= r_count - 1'b1;
                    end
                end
                bdq_pkg::ACT_POP_BACK: begin
                    if (!is_empty) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Per-item result, settled at accept or by the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act <= in_act;
            r_key <= in_val;
            r_pos <= '0;
            r_idx <= '0;
            case (in_act)
                bdq_pkg::ACT_PUSH_FRONT,
                bdq_pkg::ACT_PUSH_BACK: begin
                    r_status <= is_full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
                end
                bdq_pkg::ACT_POP_FRONT,
                bdq_pkg::ACT_POP_BACK: begin
                    r_status <= is_empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
                end
                bdq_pkg::ACT_SEARCH: begin
                    r_status <= bdq_pkg::ST_NOT_FOUND;
                end
                default: begin
                    r_status <= bdq_pkg::ST_OK;
                end
            endcase
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_status <= bdq_pkg::ST_OK;
                r_pos    <= idx_wide[bdq_pkg::POS_W-1:0];
            end else if (!scan_last) begin
                r_idx <= idx_nxt;
            end
        end
    end

    assign pop_ok = ((r_act == bdq_pkg::ACT_POP_FRONT) || (r_act == bdq_pkg::ACT_POP_BACK))
                    && (r_status == bdq_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= r_status;
            r_out_removed <= pop_ok ? rdata : '0;
            r_out_pos     <= r_pos;
            r_out_len     <= cnt_wide[bdq_pkg::LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = bdq_pkg::OUT_W'({r_out_len, r_out_pos, r_out_removed, r_out_status});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("entry count exceeds ring depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_front) < bdq_pkg::DEPTH)
        else $error("front index outside ring");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_idx < r_count))
        else $error("scan index past stored entries");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && (in_act == bdq_pkg::ACT_PUSH_BACK) && !is_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == bdq_pkg::ST_NOT_FOUND)) |-> (r_out_pos == '0))
        else $error("failed search reports a position");
`endif

endmodule

### rtl/bounded_deque_with_search.sv
// Top level of the bounded double-ended queue with value search.
// Usage:
//   The slave stream carries one command beat: tdata[2:0] action (push front,
//   push back, pop front, pop back, count, search), tdata[34:3] the value or
//   search key. Each command yields exactly one beat on the master stream:
//   status, removed value, 1-based match position and the length afterward.
// Timing:
//   A push, pop or count is accepted in IDLE and its result is loaded from DONE,
//   and the block takes the next beat once back in IDLE; the entry RAM is written or
//   read in the accept cycle and the registered read data is used in DONE.
//   A search walks the ring one entry per cycle through the RAM read port,
//   stopping at the first match or at the last live entry; an empty queue
//   goes straight from accept to DONE.
// Reset:
//   The queue comes out of reset empty with no result pending; the entry
//   RAM is not cleared, and only live entries are ever read.
// Back-pressure:
//   The result sits in an output register; while the receiver stalls, one
//   more command is accepted and worked, then held until that register frees.
module bounded_deque_with_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [2:0] action, [34:3] value, [39:35] zero
    input  logic [bdq_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [1:0] status, [33:2] removed_value, [40:34] position, [47:41] length
    output logic [bdq_pkg::OUT_W-1:0] m_axis_tdata
);

    bdq_pkg::t_cmd  cmd;
    bdq_pkg::t_stat stat;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.ready;

endmodule
